[hw/rtl/pitot_pkg.sv]
// Shared types, widths and reset constants for the pitot airspeed block.
package pitot_pkg;

  localparam int PRESS_W = 14;
  localparam int TEMP_W = 16;
  localparam int SCALE_W = 16;
  localparam int AIR_W = 16;
  localparam int CNT_W = 10;
  localparam int PROD_W = PRESS_W + SCALE_W;
  localparam int ROOT_W = PROD_W / 2;
  localparam int FILTER_SHIFT = 3;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_CALIB_SAMPLES = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_USE_FIXED_OFFSET = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FIXED_OFFSET = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SCALE_Q16 = 2'd3;

  localparam logic [CNT_W-1:0] CALIB_SAMPLES_RST = 10'd100;
  localparam logic [SCALE_W-1:0] SCALE_Q16_RST = 16'd524;

  typedef struct packed {
    logic [CNT_W-1:0] calib_samples;
    logic use_fixed_offset;
    logic [PRESS_W-1:0] fixed_offset;
    logic [SCALE_W-1:0] scale_q16;
  } cfg_t;

endpackage

[hw/rtl/pitot_regs.sv]
// APB-style configuration registers of the pitot airspeed block.
module pitot_regs (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [pitot_pkg::APB_AW-1:0] paddr,
  input  logic [pitot_pkg::APB_DW-1:0] pwdata,
  output logic [pitot_pkg::APB_DW-1:0] prdata,
  output logic pready,
  output pitot_pkg::cfg_t cfg
);

  logic [pitot_pkg::REG_IDX_W-1:0] idx;
  logic wr;

  assign pready = 1'b1;
  assign idx = paddr[pitot_pkg::APB_AW-1:2];
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.calib_samples <= pitot_pkg::CALIB_SAMPLES_RST;
      cfg.use_fixed_offset <= 1'b0;
      cfg.fixed_offset <= '0;
      cfg.scale_q16 <= pitot_pkg::SCALE_Q16_RST;
    end else if (wr) begin
      case (idx)
        pitot_pkg::REG_CALIB_SAMPLES: begin
          cfg.calib_samples <= pwdata[pitot_pkg::CNT_W-1:0];
        end
        pitot_pkg::REG_USE_FIXED_OFFSET: begin
          cfg.use_fixed_offset <= pwdata[0];
        end
        pitot_pkg::REG_FIXED_OFFSET: begin
          cfg.fixed_offset <= pwdata[pitot_pkg::PRESS_W-1:0];
        end
        pitot_pkg::REG_SCALE_Q16: begin
          cfg.scale_q16 <= pwdata[pitot_pkg::SCALE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      pitot_pkg::REG_CALIB_SAMPLES: begin
        prdata[pitot_pkg::CNT_W-1:0] = cfg.calib_samples;
      end
      pitot_pkg::REG_USE_FIXED_OFFSET: begin
        prdata[0] = cfg.use_fixed_offset;
      end
      pitot_pkg::REG_FIXED_OFFSET: begin
        prdata[pitot_pkg::PRESS_W-1:0] = cfg.fixed_offset;
      end
      pitot_pkg::REG_SCALE_Q16: begin
        prdata[pitot_pkg::SCALE_W-1:0] = cfg.scale_q16;
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/pitot_sqrt.sv]
// Iterative integer square root, one result bit per clock cycle.
module pitot_sqrt (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [pitot_pkg::PROD_W-1:0] radicand,
  output logic [pitot_pkg::ROOT_W-1:0] root,
  output logic done
);

  localparam int REM_W = pitot_pkg::ROOT_W + 3;
  localparam int ITER_W = $clog2(pitot_pkg::ROOT_W);
  localparam logic [ITER_W-1:0] LAST = ITER_W'(pitot_pkg::ROOT_W - 1);

  logic busy;
  logic [ITER_W-1:0] iter;
  logic [pitot_pkg::PROD_W-1:0] bits;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] rem_shift;
  logic [REM_W-1:0] trial;
  logic [REM_W-1:0] rem_next;
  logic [pitot_pkg::ROOT_W-1:0] root_next;

  always_comb begin
    rem_shift = {rem[REM_W-3:0], bits[pitot_pkg::PROD_W-1 -: 2]};
    trial = {1'b0, root, 2'b01};
    if (rem_shift >= trial) begin
      rem_next = rem_shift - trial;
      root_next = {root[pitot_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      rem_next = rem_shift;
      root_next = {root[pitot_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
        bits <= radicand;
        rem <= '0;
        root <= '0;
      end else if (busy) begin
        bits <= {bits[pitot_pkg::PROD_W-3:0], 2'b00};
        rem <= rem_next;
        root <= root_next;
        iter <= iter + 1'b1;
        if (iter == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hw/rtl/pitot_airspeed_from_pressure.sv]
// Top level of the pitot airspeed block: sequencer, calibration and smoothing.
// The block takes one four-byte sensor word at a time and returns one result word for it.
// A rejected or calibration word has its result word valid in the cycle after it is accepted.
// A measurement word passes in order through the multiply, the root load, the square-root
// unit, which resolves one root bit per cycle, the handoff of the root's done flag and the
// filter, and its result word is then valid.
// in_ready stays low from acceptance until the result word has been taken, so the block
// accepts no new word while the result word for the last one is still pending.
module pitot_airspeed_from_pressure #(
  parameter int FILTER_SHIFT = pitot_pkg::FILTER_SHIFT
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [pitot_pkg::APB_AW-1:0] paddr,
  input  logic [pitot_pkg::APB_DW-1:0] pwdata,
  output logic [pitot_pkg::APB_DW-1:0] prdata,
  output logic pready,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] byte0,
  input  logic [7:0] byte1,
  input  logic [7:0] byte2,
  input  logic [7:0] byte3,
  output logic out_valid,
  input  logic out_ready,
  output logic [pitot_pkg::PRESS_W-1:0] pressure_raw,
  output logic [pitot_pkg::TEMP_W-1:0] temperature_raw,
  output logic reading_valid,
  output logic calibrating,
  output logic [pitot_pkg::PRESS_W-1:0] offset_now,
  output logic [pitot_pkg::AIR_W-1:0] airspeed_q8,
  output logic airspeed_updated
);

  localparam int OFS_ACC_W = pitot_pkg::PRESS_W + FILTER_SHIFT + 1;
  localparam int AIR_ACC_W = pitot_pkg::AIR_W + FILTER_SHIFT + 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_LOAD = 6'b000100,
    S_ROOT = 6'b001000,
    S_FILT = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state;
  pitot_pkg::cfg_t cfg;

  logic [pitot_pkg::PRESS_W-1:0] p_in;
  logic [pitot_pkg::TEMP_W-1:0] t_in;
  logic good;
  logic cal;
  logic [pitot_pkg::PRESS_W-1:0] pressure_offset;
  logic [pitot_pkg::CNT_W-1:0] calib_done_count;
  logic [pitot_pkg::AIR_W-1:0] airspeed_filtered;
  logic [pitot_pkg::PRESS_W-1:0] diff;
  logic [pitot_pkg::PROD_W-1:0] prod;
  logic [OFS_ACC_W-1:0] ofs_acc;
  logic [AIR_ACC_W-1:0] air_acc;
  logic [pitot_pkg::ROOT_W-1:0] root;
  logic root_done;

  pitot_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pitot_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_LOAD),
    .radicand (prod),
    .root     (root),
    .done     (root_done)
  );

  assign p_in = {byte0[5:0], byte1};
  assign t_in = {byte2, byte3[7:5], 5'b00000};
  assign good = (p_in != '0) && (t_in != '0);
  assign cal = good && (calib_done_count < cfg.calib_samples);

  assign ofs_acc = (OFS_ACC_W'(pressure_offset) << FILTER_SHIFT) -
                   OFS_ACC_W'(pressure_offset) + OFS_ACC_W'(p_in);
  assign air_acc = (AIR_ACC_W'(airspeed_filtered) << FILTER_SHIFT) -
                   AIR_ACC_W'(airspeed_filtered) + AIR_ACC_W'(root);

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_DONE);
  assign offset_now = pressure_offset;
  assign airspeed_q8 = airspeed_filtered;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pressure_offset <= '0;
      calib_done_count <= '0;
      airspeed_filtered <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            pressure_raw <= p_in;
            temperature_raw <= t_in;
            reading_valid <= good;
            calibrating <= cal;
            airspeed_updated <= good && !cal;
            diff <= (p_in > pressure_offset) ? (p_in - pressure_offset) : '0;
            if (cal) begin
              pressure_offset <= cfg.use_fixed_offset ? cfg.fixed_offset :
                                 ofs_acc[FILTER_SHIFT +: pitot_pkg::PRESS_W];
              calib_done_count <= calib_done_count + 1'b1;
            end
            state <= (good && !cal) ? S_MUL : S_DONE;
          end
        end
        S_MUL: begin
          prod <= pitot_pkg::PROD_W'(diff * cfg.scale_q16);
          state <= S_LOAD;
        end
        S_LOAD: begin
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (root_done) begin
            state <= S_FILT;
          end
        end
        S_FILT: begin
          airspeed_filtered <= air_acc[FILTER_SHIFT +: pitot_pkg::AIR_W];
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
